[rtl/hdlf_pkg.sv]
// shared types, constants and character layout table of the hex dump line formatter
`timescale 1ns / 1ps

package hdlf_pkg;

    // line geometry
    localparam int LINE_BYTES = 16;
    localparam int LINE_CHARS = 78;
    localparam int IDX_W      = $clog2(LINE_BYTES);
    localparam int BUF_DEPTH  = 2 * LINE_BYTES;
    localparam int BUF_AW     = $clog2(BUF_DEPTH);
    localparam int POS_W      = $clog2(LINE_CHARS);
    localparam int HAVE_W     = IDX_W + 1;
    localparam int OFS_W      = 32;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_CHARS - 1);

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_LOW   = 8'h20;
    localparam logic [7:0] CH_HIGH  = 8'h7E;

    // what a character position of the line shows
    typedef enum logic [2:0] {
        CK_SPACE = 3'd0,
        CK_OFS   = 3'd1,
        CK_HI    = 3'd2,
        CK_LO    = 3'd3,
        CK_GLYPH = 3'd4,
        CK_BAR   = 3'd5,
        CK_NL    = 3'd6
    } char_kind_t;

    typedef struct packed {
        char_kind_t       kind;
        logic [IDX_W-1:0] idx;   // byte index, or offset nibble from the top
    } char_map_t;

    typedef char_map_t [LINE_CHARS-1:0] char_tbl_t;

    // one completed line handed to the formatter
    typedef struct packed {
        logic [OFS_W-1:0]  offset;
        logic [HAVE_W-1:0] have;
        logic              bank;
        logic              last_line;
    } line_desc_t;

    // layout of one text line, built at elaboration
    function automatic char_tbl_t build_char_map();
        char_tbl_t m;
        int p;
        m = '0;
        p = 0;
        for (int i = 0; i < 8; i++) begin
            m[p].kind = CK_OFS;
            m[p].idx  = IDX_W'(i);
            p++;
        end
        p++;
        for (int k = 0; k < LINE_BYTES; k++) begin
            if (k == LINE_BYTES / 2) begin
                p++;
            end
            m[p].kind     = CK_HI;
            m[p].idx      = IDX_W'(k);
            m[p + 1].kind = CK_LO;
            m[p + 1].idx  = IDX_W'(k);
            p += 3;
        end
        m[p].kind = CK_BAR;
        p += 2;
        for (int k = 0; k < LINE_BYTES; k++) begin
            if (k == LINE_BYTES / 2) begin
                p++;
            end
            m[p].kind = CK_GLYPH;
            m[p].idx  = IDX_W'(k);
            p++;
        end
        m[p].kind = CK_NL;
        return m;
    endfunction

    localparam char_tbl_t CHAR_MAP = build_char_map();

    // upper-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
    endfunction

endpackage

[rtl/hdlf_fmt.sv]
// line formatter: walks the 78 character positions, reads the line buffer and packs words
`timescale 1ns / 1ps

module hdlf_fmt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  hdlf_pkg::line_desc_t       desc_in,
    output logic                       idle,
    output logic [hdlf_pkg::BUF_AW-1:0] rd_addr,
    input  logic [7:0]                 rd_data,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [71:0]                m_tdata,  // text_word[63:0], char_count[67:64], zero fill
    output logic                       m_tlast,  // dump_end
    output logic                       m_tuser   // line_end
);
    import hdlf_pkg::*;

    line_desc_t       desc_reg;
    logic             a_vld_reg;
    logic [POS_W-1:0] a_pos_reg;
    logic             b_vld_reg;
    logic [POS_W-1:0] b_pos_reg;
    logic [55:0]      acc_reg;
    logic             out_vld_reg;
    logic [63:0]      out_word_reg;
    logic [3:0]       out_cnt_reg;
    logic             out_line_end_reg;
    logic             out_dump_end_reg;

    char_map_t   a_map;
    char_map_t   b_map;
    logic        b_done;
    logic        advance;
    logic        present;
    logic [2:0]  nib_sel;
    logic [3:0]  ofs_nib;
    logic [7:0]  ch;
    logic [63:0] word_full;

    assign a_map = CHAR_MAP[a_pos_reg];
    assign b_map = CHAR_MAP[b_pos_reg];

    // word boundary every eight characters and at the newline
    assign b_done  = (b_pos_reg[2:0] == 3'd7) || (b_pos_reg == LAST_POS);
    assign advance = !(b_vld_reg && b_done && out_vld_reg && !m_tready);
    assign idle    = !a_vld_reg && !b_vld_reg;

    // read the byte for the next position, or hold the current one while stalled
    assign rd_addr = {desc_reg.bank, (advance ? a_map.idx : b_map.idx)};

    // character of the position in the second stage
    assign present = {1'b0, b_map.idx} < desc_reg.have;
    assign nib_sel = 3'd7 - b_map.idx[2:0];
    assign ofs_nib = 4'(desc_reg.offset >> {nib_sel, 2'b00});

    always_comb begin
        unique case (b_map.kind)
            CK_OFS:   ch = hex_char(ofs_nib);
            CK_HI:    ch = present ? hex_char(rd_data[7:4]) : CH_SPACE;
            CK_LO:    ch = present ? hex_char(rd_data[3:0]) : CH_SPACE;
            CK_GLYPH: begin
                if (!present) begin
                    ch = CH_SPACE;
                end else if (rd_data >= CH_LOW && rd_data <= CH_HIGH) begin
                    ch = rd_data;
                end else begin
                    ch = CH_DOT;
                end
            end
            CK_BAR:   ch = CH_BAR;
            CK_NL:    ch = CH_NL;
            default:  ch = CH_SPACE;
        endcase
    end

    assign word_full = {8'h00, acc_reg} | ({56'd0, ch} << {b_pos_reg[2:0], 3'b000});

    // sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (start) begin
                a_vld_reg <= 1'b1;
            end else if (advance) begin
                if (a_vld_reg && a_pos_reg == LAST_POS) begin
                    a_vld_reg <= 1'b0;
                end
                b_vld_reg <= a_vld_reg;
            end
            if (b_vld_reg && b_done && advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // positions, word assembly and output payload
    always_ff @(posedge aclk) begin
        if (start) begin
            desc_reg  <= desc_in;
            a_pos_reg <= '0;
            acc_reg   <= '0;
        end else if (advance) begin
            // first stage stops on the newline position
            if (a_vld_reg && a_pos_reg != LAST_POS) begin
                a_pos_reg <= a_pos_reg + POS_W'(1);
            end
            b_pos_reg <= a_pos_reg;
            if (b_vld_reg) begin
                acc_reg <= b_done ? 56'd0 : word_full[55:0];
            end
        end
        if (b_vld_reg && b_done && advance) begin
            out_word_reg     <= word_full;
            out_cnt_reg      <= {1'b0, b_pos_reg[2:0]} + 4'd1;
            out_line_end_reg <= (b_pos_reg == LAST_POS);
            out_dump_end_reg <= (b_pos_reg == LAST_POS) && desc_reg.last_line;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'h0, out_cnt_reg, out_word_reg};
    assign m_tlast  = out_dump_end_reg;
    assign m_tuser  = out_line_end_reg;

endmodule

[rtl/hex_dump_line_formatter.sv]
// Path: the byte that closes the line sets the pending descriptor; when the formatter is free it
// loads it, and the first word is valid in the output register once its eight characters are through.
// Throughput: one character per cycle while the output does not stall, set by the formatter
// walking the 78 character positions through the buffer read port; a line is 10 words.
// Bytes go in at one per cycle into one half of a double line buffer while the other half
// is formatted; input stalls when a closed line waits for the formatter.
// Reset: synchronous, active low; clears counters, offset and valids, not the line buffer.
`timescale 1ns / 1ps

module hex_dump_line_formatter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // text_word[63:0], char_count[67:64], zero fill
    output logic        m_tlast,   // dump_end
    output logic        m_tuser    // line_end
);
    import hdlf_pkg::*;

    logic [7:0]        line_mem [BUF_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              wbank_reg;
    logic [IDX_W-1:0]  wcnt_reg;
    logic [OFS_W-1:0]  line_offset_reg;
    logic              pend_reg;
    line_desc_t        pend_desc_reg;

    logic              s_accept;
    logic              line_done;
    logic              fmt_idle;
    logic              fmt_start;
    logic [BUF_AW-1:0] rd_addr;

    assign s_tready  = !pend_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign line_done = s_accept && (s_tlast || wcnt_reg == IDX_W'(LINE_BYTES - 1));
    assign fmt_start = pend_reg && fmt_idle;

    // double line buffer
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            line_mem[{wbank_reg, wcnt_reg}] <= s_tdata;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    // byte gathering and line hand-off
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wbank_reg       <= 1'b0;
            wcnt_reg        <= '0;
            line_offset_reg <= '0;
            pend_reg        <= 1'b0;
        end else begin
            if (line_done) begin
                pend_reg        <= 1'b1;
                wcnt_reg        <= '0;
                wbank_reg       <= !wbank_reg;
                line_offset_reg <= s_tlast ? '0 : line_offset_reg + OFS_W'(LINE_BYTES);
            end else if (s_accept) begin
                wcnt_reg <= wcnt_reg + IDX_W'(1);
            end
            if (fmt_start) begin
                pend_reg <= 1'b0;
            end
        end
    end

    // descriptor of the closed line
    always_ff @(posedge aclk) begin
        if (line_done) begin
            pend_desc_reg.offset    <= line_offset_reg;
            pend_desc_reg.have      <= {1'b0, wcnt_reg} + HAVE_W'(1);
            pend_desc_reg.bank      <= wbank_reg;
            pend_desc_reg.last_line <= s_tlast;
        end
    end

    hdlf_fmt u_fmt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (fmt_start),
        .desc_in  (pend_desc_reg),
        .idle     (fmt_idle),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/hdlf_checker.sv]
// port checker of the hex dump line formatter and its bind
`timescale 1ns / 1ps

module hdlf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // end of dump only on the word closing a line
    a_dump_end_on_line_end: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser
    ) else $error("dump end on a word that does not close a line");

    // closing word: six characters ending in newline, upper bytes zero
    a_line_end_word: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (m_tdata[67:64] == 4'd6 && m_tdata[47:40] == 8'h0A && m_tdata[63:48] == 16'h0)
    ) else $error("malformed line end word");

    // other words carry eight characters
    a_full_word: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[67:64] == 4'd8)
    ) else $error("inner word without eight characters");

    // stalled transaction holds
    a_out_hold: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    ) else $error("output transaction changed while stalled");

    // input stalls right after the transaction that ends a dump
    a_stall_after_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready
    ) else $error("input ready right after the end of a dump");

endmodule

bind hex_dump_line_formatter hdlf_checker u_hdlf_checker (.*);

[bench/tb_hex_dump_line_formatter.sv]
// testbench for the hex dump line formatter: stimulus table, random dumps, predictor and checker
`timescale 1ns / 1ps

module tb_hex_dump_line_formatter;

    localparam int CLK_HALF    = 10;
    localparam int QUIET_LIMIT = 4000;   // cycles with no transaction on either side
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int MAX_REPORTS = 40;
    localparam int TAIL_CYCLES = 120;    // about one line of formatting time
    localparam int RAND_BYTES  = 145;
    localparam int DIR_ROWS    = 25;

    // text layout of one line
    localparam int LINE_LEN  = 16;
    localparam int TEXT_LEN  = 78;
    localparam int WORDS     = 10;
    localparam int HEX_POS   = 9;
    localparam int HEX_GAP   = 33;
    localparam int BAR_POS   = 58;
    localparam int GLYPH_POS = 60;
    localparam int GLYPH_GAP = 68;
    localparam int NL_POS    = 77;

    localparam logic [7:0] SP   = 8'h20;
    localparam logic [7:0] DOT  = 8'h2E;
    localparam logic [7:0] BAR  = 8'h7C;
    localparam logic [7:0] NL   = 8'h0A;
    localparam logic [7:0] PR_LO = 8'h20;
    localparam logic [7:0] PR_HI = 8'h7E;

    // first text word of a line, typed in from the offset
    localparam logic [63:0] OFS_0000 = 64'h3030303030303030;   // "00000000"
    localparam logic [63:0] OFS_0010 = 64'h3031303030303030;   // "00000010"

    typedef struct {
        logic [63:0] text;
        logic [3:0]  count;
        logic        line_end;
        logic        dump_end;
    } dump_word_t;

    typedef struct packed {
        logic [7:0]  dbyte;
        logic        last;
        logic        known;   // word0 holds the typed first word of the line this row closes
        logic [63:0] word0;
    } dir_row_t;

    // directed rows: one-byte dump, a full line of edge bytes then a one-byte short line,
    // and a seven-byte line of digits, letters and a control code
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{8'h41, 1'b1, 1'b1, OFS_0000},
        '{8'h00, 1'b0, 1'b0, 64'h0},
        '{8'hFF, 1'b0, 1'b0, 64'h0},
        '{8'h1F, 1'b0, 1'b0, 64'h0},
        '{8'h20, 1'b0, 1'b0, 64'h0},
        '{8'h7E, 1'b0, 1'b0, 64'h0},
        '{8'h7F, 1'b0, 1'b0, 64'h0},
        '{8'h80, 1'b0, 1'b0, 64'h0},
        '{8'h01, 1'b0, 1'b0, 64'h0},
        '{8'h23, 1'b0, 1'b0, 64'h0},
        '{8'h45, 1'b0, 1'b0, 64'h0},
        '{8'h67, 1'b0, 1'b0, 64'h0},
        '{8'h89, 1'b0, 1'b0, 64'h0},
        '{8'hAB, 1'b0, 1'b0, 64'h0},
        '{8'hCD, 1'b0, 1'b0, 64'h0},
        '{8'hEF, 1'b0, 1'b0, 64'h0},
        '{8'h5A, 1'b0, 1'b1, OFS_0000},
        '{8'h55, 1'b1, 1'b1, OFS_0010},
        '{8'h30, 1'b0, 1'b0, 64'h0},
        '{8'h39, 1'b0, 1'b0, 64'h0},
        '{8'h41, 1'b0, 1'b0, 64'h0},
        '{8'h46, 1'b0, 1'b0, 64'h0},
        '{8'h61, 1'b0, 1'b0, 64'h0},
        '{8'h7A, 1'b0, 1'b0, 64'h0},
        '{8'h09, 1'b1, 1'b1, OFS_0000}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // predictor state
    logic [7:0]  line_store [LINE_LEN];
    logic [4:0]  line_fill = '0;
    logic [31:0] line_base = '0;

    dump_word_t  pending_words [$];

    int err_count   = 0;
    int quiet       = 0;
    int burst_left  = 0;
    int bytes_sent  = 0;
    int dumps_done  = 0;
    int lines_done  = 0;
    int words_seen  = 0;
    logic [31:0] top_offset = '0;
    bit hold_req    = 1'b0;

    hex_dump_line_formatter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        string digits;
        digits = "0123456789ABCDEF";
        return digits[n];
    endfunction

    // format the held line and queue its ten text words
    task automatic format_line(input logic final_line, input logic known,
                               input logic [63:0] word0);
        logic [7:0] txt [WORDS * 8];
        logic [7:0] b;
        dump_word_t w;
        int pos;
        for (int i = 0; i < WORDS * 8; i++) txt[i] = 8'h00;
        for (int i = 0; i < 8; i++) txt[i] = nibble_char(line_base[31 - 4 * i -: 4]);
        txt[8] = SP;
        txt[HEX_GAP] = SP;
        txt[BAR_POS] = BAR;
        txt[BAR_POS + 1] = SP;
        txt[GLYPH_GAP] = SP;
        txt[NL_POS] = NL;
        for (int k = 0; k < LINE_LEN; k++) begin
            b = line_store[k];
            pos = HEX_POS + 3 * k + ((k >= 8) ? 1 : 0);
            // missing positions of a short line print as blanks
            if (k < line_fill) begin
                txt[pos]     = nibble_char(b[7:4]);
                txt[pos + 1] = nibble_char(b[3:0]);
            end else begin
                txt[pos]     = SP;
                txt[pos + 1] = SP;
            end
            txt[pos + 2] = SP;
            pos = GLYPH_POS + k + ((k >= 8) ? 1 : 0);
            if (k >= line_fill) begin
                txt[pos] = SP;
            end else if (b >= PR_LO && b <= PR_HI) begin
                txt[pos] = b;
            end else begin
                txt[pos] = DOT;
            end
        end
        for (int wi = 0; wi < WORDS; wi++) begin
            w.text = '0;
            w.count = (wi < WORDS - 1) ? 4'd8 : 4'(TEXT_LEN - 8 * (WORDS - 1));
            for (int i = 0; i < w.count; i++) w.text[8 * i +: 8] = txt[wi * 8 + i];
            if (wi == 0 && known) begin
                w.text = word0;
            end
            w.line_end = (wi == WORDS - 1);
            w.dump_end = (wi == WORDS - 1) && final_line;
            pending_words.push_back(w);
        end
        lines_done++;
        if (line_base > top_offset) begin
            top_offset = line_base;
        end
    endtask

    // update the line state for one accepted byte
    task automatic take_byte(input logic [7:0] d, input logic l, input logic known,
                             input logic [63:0] word0);
        line_store[line_fill[3:0]] = d;
        line_fill = line_fill + 5'd1;
        if (line_fill == 5'(LINE_LEN) || l) begin
            format_line(l, known, word0);
            line_fill = '0;
            if (l) begin
                line_base = '0;
                dumps_done++;
            end else begin
                line_base = line_base + 32'(LINE_LEN);
            end
        end
    endtask

    // offer one byte, with bursts and random gaps on the sender side
    task automatic offer_byte(input logic [7:0] d, input logic l, input logic known,
                              input logic [63:0] word0);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        take_byte(d, l, known, word0);
        bytes_sent++;
    endtask

    // stop offering until every queued word has come out
    task automatic drain_words();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
    endtask

    task automatic report_diff(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, exp_v, act_v);
        end
    endtask

    // receiver: segments of varying readiness, plus a long hold-off on request
    initial begin
        int hold_left;
        int seg_left;
        int ready_pct;
        hold_left = 0;
        seg_left  = 0;
        ready_pct = 100;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 70;
                        2: ready_pct = 35;
                        default: ready_pct = 10;
                    endcase
                    seg_left = $urandom_range(20, 120);
                end
                seg_left--;
                m_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    // compare each output transaction with the oldest queued word
    always @(posedge aclk) begin
        dump_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                report_diff("unexpected word", 64'h0, m_tdata[63:0]);
            end else begin
                w = pending_words.pop_front();
                if (m_tdata[63:0] !== w.text) begin
                    report_diff("text_word", w.text, m_tdata[63:0]);
                end
                if (m_tdata[67:64] !== w.count) begin
                    report_diff("char_count", 64'(w.count), 64'(m_tdata[67:64]));
                end
                if (m_tdata[71:68] !== 4'h0) begin
                    report_diff("tdata fill", 64'h0, 64'(m_tdata[71:68]));
                end
                if (m_tuser !== w.line_end) begin
                    report_diff("line_end", 64'(w.line_end), 64'(m_tuser));
                end
                if (m_tlast !== w.dump_end) begin
                    report_diff("dump_end", 64'(w.dump_end), 64'(m_tlast));
                end
            end
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d words still expected",
                     $time, quiet, pending_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // stimulus
    initial begin
        int len;
        int rand_bytes;
        bit paused;
        rand_bytes = 0;
        paused     = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            offer_byte(dir_rows[r].dbyte, dir_rows[r].last, dir_rows[r].known,
                       dir_rows[r].word0);
        end
        drain_words();

        // random dumps; the first spans several lines and runs into a long
        // receiver hold-off
        while (rand_bytes < RAND_BYTES) begin
            if (rand_bytes == 0) begin
                len = $urandom_range(113, 128);
                hold_req = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1: len = 16 * $urandom_range(1, 2);   // ends exactly on a full line
                    2: len = 1;
                    default: len = $urandom_range(2, 40);
                endcase
            end
            for (int i = 0; i < len; i++) begin
                offer_byte(8'($urandom_range(0, 255)), (i == len - 1), 1'b0, 64'h0);
            end
            rand_bytes += len;
            if (!paused && rand_bytes >= RAND_BYTES - 20) begin
                drain_words();
                paused = 1'b1;
            end
        end
        drain_words();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d bytes in %0d dumps: %0d lines, %0d words checked",
                 bytes_sent, dumps_done, lines_done, words_seen);
        $display("highest line offset %h, edge bytes, short and one-byte final lines",
                 top_offset);
        if (err_count == 0 && pending_words.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
rtl/hdlf_pkg.sv
rtl/hdlf_fmt.sv
rtl/hex_dump_line_formatter.sv
rtl/hdlf_checker.sv
bench/tb_hex_dump_line_formatter.sv
